@@ src/sliding_window_median_position_macros.svh @@
// assertion macros shared by the median window rtl
`ifndef SLIDING_WINDOW_MEDIAN_POSITION_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_POSITION_MACROS_SVH
`ifndef SYNTHESIS
// plain property, checked at every edge outside reset
`define SWMP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// cause in this cycle, effect in the next
`define SWMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SWMP_ASSERT(lbl, clk, rst_n, prop, msg)
`define SWMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ src/swmp_pkg.sv @@
// shared types and constants of the median window
`timescale 1ns / 1ps
package swmp_pkg;

	localparam int NCH     = 5;
	localparam int CFG_W   = 5;
	localparam int HELD_W  = 5;

	localparam int CH_REL_X = 0;
	localparam int CH_REL_Y = 1;
	localparam int CH_REL_Z = 2;
	localparam int CH_ABS_X = 3;
	localparam int CH_ABS_Y = 4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_RANK,
		ST_DONE
	} swmp_state_t;

	typedef struct packed {
		logic shift;
		logic load_probe;
		logic rotate;
	} swmp_cell_ctl_t;

endpackage

@@ src/swmp_channels.sv @@
// valid/ready channel interfaces for samples and medians
`timescale 1ns / 1ps
interface swmp_sample_if #(
	parameter int SAMPLE_WIDTH = 32
);
	logic                           valid;
	logic                           ready;
	logic                           detected;
	logic signed [SAMPLE_WIDTH-1:0] rel_x;
	logic signed [SAMPLE_WIDTH-1:0] rel_y;
	logic signed [SAMPLE_WIDTH-1:0] rel_z;
	logic signed [SAMPLE_WIDTH-1:0] abs_x;
	logic signed [SAMPLE_WIDTH-1:0] abs_y;

	modport source (output valid, detected, rel_x, rel_y, rel_z, abs_x, abs_y, input ready);
	modport sink (input valid, detected, rel_x, rel_y, rel_z, abs_x, abs_y, output ready);
endinterface

interface swmp_median_if #(
	parameter int SAMPLE_WIDTH = 32
);
	logic                              valid;
	logic                              ready;
	logic                              has_position;
	logic signed [SAMPLE_WIDTH-1:0]    med_rel_x;
	logic signed [SAMPLE_WIDTH-1:0]    med_rel_y;
	logic signed [SAMPLE_WIDTH-1:0]    med_rel_z;
	logic signed [SAMPLE_WIDTH-1:0]    med_abs_x;
	logic signed [SAMPLE_WIDTH-1:0]    med_abs_y;
	logic [swmp_pkg::HELD_W-1:0]       held_count;

	modport source (output valid, has_position, med_rel_x, med_rel_y, med_rel_z, med_abs_x,
		med_abs_y, held_count, input ready);
	modport sink (input valid, has_position, med_rel_x, med_rel_y, med_rel_z, med_abs_x,
		med_abs_y, held_count, output ready);
endinterface

@@ src/sliding_window_median_position.sv @@
// top level: sliding-window upper median of five-channel position samples
//
// samples come in on the sample channel, one transfer per camera detection;
// detected = 1 carries a sample, detected = 0 marks a missed detection.
// one result transfer leaves on the median channel for every sample transfer.
// the user writes window_size through cfg_we / cfg_wdata while the block is idle; the block does not enforce it.
// the window lives in a row of WINDOW_MAX cells, newest sample in cell 0;
// an append shifts the row by one cell, the oldest sample sits at count - 1.
// a detection goes from transfer to result register through these steps:
// load the probe ring, WINDOW_MAX ring rotations in which every cell ranks
// its own value against each probe, then the pick into the result register.
// a miss only drops the oldest sample; its result skips the rank pass.
// a new sample is taken only once the result of the one before has gone
// into the result register, so the rank pass holds off the next sample.
// reset empties the window (count zero) and sets window_size to five;
// the cell contents need no clearing since only filled cells are read.
// a result waits in the output register while the receiver stalls; the next
// sample is already taken then, and its result waits until the register frees.
`timescale 1ns / 1ps
`include "sliding_window_median_position_macros.svh"
module sliding_window_median_position #(
	parameter int WINDOW_MAX   = 16,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [swmp_pkg::CFG_W-1:0] cfg_wdata,
	swmp_sample_if.sink                sample,
	swmp_median_if.source              median
);

	// count holds 0..WINDOW_MAX, cell positions and ranks 0..WINDOW_MAX-1
	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

	typedef logic [swmp_pkg::NCH-1:0][SAMPLE_WIDTH-1:0] chans_t;

	swmp_pkg::swmp_cell_ctl_t ctl;
	logic [CW-1:0]            count;
	logic [IW-1:0]            target;
	logic                     has_pos;
	logic                     load_out;
	logic                     out_free;

	chans_t                   sample_vec;
	chans_t                   chain_val [WINDOW_MAX];
	chans_t                   probe_val [WINDOW_MAX];
	logic [IW-1:0]            probe_tag [WINDOW_MAX];
	chans_t                   pick      [WINDOW_MAX];
	chans_t                   med_sel;

	chans_t                   med_q;
	logic                     has_q;
	logic [swmp_pkg::HELD_W-1:0] held_q;
	logic                     valid_q;

	// gather the five channels into one word for the shift row
	always_comb begin
		sample_vec                     = '0;
		sample_vec[swmp_pkg::CH_REL_X] = sample.rel_x;
		sample_vec[swmp_pkg::CH_REL_Y] = sample.rel_y;
		sample_vec[swmp_pkg::CH_REL_Z] = sample.rel_z;
		sample_vec[swmp_pkg::CH_ABS_X] = sample.abs_x;
		sample_vec[swmp_pkg::CH_ABS_Y] = sample.abs_y;
	end

	// result register is free when empty or being taken this cycle
	assign out_free = !valid_q || median.ready;

	swmp_ctrl #(
		.WINDOW_MAX (WINDOW_MAX),
		.CW         (CW),
		.IW         (IW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (sample.valid),
		.in_detected (sample.detected),
		.in_ready    (sample.ready),
		.out_free    (out_free),
		.load_out    (load_out),
		.ctl         (ctl),
		.count       (count),
		.target      (target),
		.has_pos     (has_pos)
	);

	// row of cells: samples shift towards higher cells, probes circulate as a ring
	for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
		localparam int PREV = (g == 0) ? WINDOW_MAX - 1 : g - 1;
		chans_t shift_src;

		if (g == 0) begin : g_head
			assign shift_src = sample_vec;
		end else begin : g_body
			assign shift_src = chain_val[PREV];
		end

		swmp_cell #(
			.SAMPLE_WIDTH (SAMPLE_WIDTH),
			.CW           (CW),
			.IW           (IW),
			.INDEX        (g)
		) u_cell (
			.clk           (clk),
			.ctl           (ctl),
			.count         (count),
			.target        (target),
			.shift_in_val  (shift_src),
			.shift_out_val (chain_val[g]),
			.probe_in_val  (probe_val[PREV]),
			.probe_in_tag  (probe_tag[PREV]),
			.probe_out_val (probe_val[g]),
			.probe_out_tag (probe_tag[g]),
			.pick          (pick[g])
		);
	end

	// exactly one filled cell per channel holds the target rank
	always_comb begin
		med_sel = '0;
		for (int i = 0; i < WINDOW_MAX; i++) begin
			med_sel = med_sel | pick[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_out) begin
			valid_q <= 1'b1;
		end else if (median.ready) begin
			valid_q <= 1'b0;
		end
	end

	// result payload, medians forced to zero on a miss
	always_ff @(posedge clk) begin
		if (load_out) begin
			med_q  <= has_pos ? med_sel : '0;
			has_q  <= has_pos;
			held_q <= swmp_pkg::HELD_W'(count);
		end
	end

	assign median.valid        = valid_q;
	assign median.has_position = has_q;
	assign median.med_rel_x    = med_q[swmp_pkg::CH_REL_X];
	assign median.med_rel_y    = med_q[swmp_pkg::CH_REL_Y];
	assign median.med_rel_z    = med_q[swmp_pkg::CH_REL_Z];
	assign median.med_abs_x    = med_q[swmp_pkg::CH_ABS_X];
	assign median.med_abs_y    = med_q[swmp_pkg::CH_ABS_Y];
	assign median.held_count   = held_q;

	`SWMP_ASSERT(a_miss_zero, clk, arst_n, (median.valid && !median.has_position) |-> ((median.med_rel_x == '0) && (median.med_rel_y == '0) && (median.med_rel_z == '0) && (median.med_abs_x == '0) && (median.med_abs_y == '0)), "missed detection carries a non-zero median")

endmodule

@@ src/swmp_cell.sv @@
// one window cell: stored sample, circulating probe and per-channel rank counters
`timescale 1ns / 1ps
module swmp_cell #(
	parameter int SAMPLE_WIDTH = 32,
	parameter int CW           = 5,
	parameter int IW           = 4,
	parameter int INDEX        = 0
) (
	input  logic                                            clk,
	input  swmp_pkg::swmp_cell_ctl_t                        ctl,
	input  logic [CW-1:0]                                   count,
	input  logic [IW-1:0]                                   target,
	input  logic [swmp_pkg::NCH-1:0][SAMPLE_WIDTH-1:0]      shift_in_val,
	output logic [swmp_pkg::NCH-1:0][SAMPLE_WIDTH-1:0]      shift_out_val,
	input  logic [swmp_pkg::NCH-1:0][SAMPLE_WIDTH-1:0]      probe_in_val,
	input  logic [IW-1:0]                                   probe_in_tag,
	output logic [swmp_pkg::NCH-1:0][SAMPLE_WIDTH-1:0]      probe_out_val,
	output logic [IW-1:0]                                   probe_out_tag,
	output logic [swmp_pkg::NCH-1:0][SAMPLE_WIDTH-1:0]      pick
);

	localparam logic [CW-1:0] MY_POS = CW'(INDEX);
	localparam logic [IW-1:0] MY_TAG = IW'(INDEX);

	logic [swmp_pkg::NCH-1:0][SAMPLE_WIDTH-1:0] val_q;
	logic [swmp_pkg::NCH-1:0][SAMPLE_WIDTH-1:0] probe_val_q;
	logic [IW-1:0]                              probe_tag_q;
	logic [swmp_pkg::NCH-1:0][IW-1:0]           rank_q;
	logic [swmp_pkg::NCH-1:0]                   beats;
	logic                                       probe_live;
	logic                                       in_window;

	assign probe_live = CW'(probe_tag_q) < count;
	assign in_window  = MY_POS < count;

	// probe ranks below this cell's value, ties broken by position
	always_comb begin
		for (int c = 0; c < swmp_pkg::NCH; c++) begin
			beats[c] = probe_live &&
				(($signed(probe_val_q[c]) < $signed(val_q[c])) ||
				 ((probe_val_q[c] == val_q[c]) && (probe_tag_q < MY_TAG)));
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			val_q <= shift_in_val;
		end
		if (ctl.load_probe) begin
			probe_val_q <= val_q;
			probe_tag_q <= MY_TAG;
			rank_q      <= '0;
		end else if (ctl.rotate) begin
			probe_val_q <= probe_in_val;
			probe_tag_q <= probe_in_tag;
			for (int c = 0; c < swmp_pkg::NCH; c++) begin
				if (beats[c]) begin
					rank_q[c] <= rank_q[c] + IW'(1);
				end
			end
		end
	end

	always_comb begin
		for (int c = 0; c < swmp_pkg::NCH; c++) begin
			pick[c] = (in_window && (rank_q[c] == target)) ? val_q[c] : '0;
		end
	end

	assign shift_out_val = val_q;
	assign probe_out_val = probe_val_q;
	assign probe_out_tag = probe_tag_q;

endmodule

@@ src/swmp_ctrl.sv @@
// sequencer: window size register, fill count and rank pass timing
`timescale 1ns / 1ps
`include "sliding_window_median_position_macros.svh"
module swmp_ctrl #(
	parameter int WINDOW_MAX = 16,
	parameter int CW         = 5,
	parameter int IW         = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [swmp_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic                        in_valid,
	input  logic                        in_detected,
	output logic                        in_ready,
	input  logic                        out_free,
	output logic                        load_out,
	output swmp_pkg::swmp_cell_ctl_t    ctl,
	output logic [CW-1:0]               count,
	output logic [IW-1:0]               target,
	output logic                        has_pos
);

	localparam int EW = (CW > swmp_pkg::CFG_W) ? CW : swmp_pkg::CFG_W;
	localparam logic [EW-1:0] WMAX = EW'(WINDOW_MAX);
	localparam logic [IW-1:0] LAST = IW'(WINDOW_MAX - 1);

	swmp_pkg::swmp_state_t        state_q, state_n;
	logic [CW-1:0]                count_q;
	logic [swmp_pkg::CFG_W-1:0]   ws_q;
	logic [IW-1:0]                cyc_q;
	logic                         has_pos_q;
	logic [EW-1:0]                ws_ext;
	logic [EW-1:0]                eff;
	logic                         full;
	logic                         accept;

	// zero acts as one, anything above the cell count as the cell count
	always_comb begin
		ws_ext = EW'(ws_q);
		if (ws_ext == '0) begin
			eff = EW'(1);
		end else if (ws_ext > WMAX) begin
			eff = WMAX;
		end else begin
			eff = ws_ext;
		end
	end

	assign full   = EW'(count_q) >= eff;
	assign accept = (state_q == swmp_pkg::ST_IDLE) && in_valid;

	always_comb begin
		state_n = state_q;
		case (state_q)
			swmp_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_n = in_detected ? swmp_pkg::ST_LOAD : swmp_pkg::ST_DONE;
				end
			end
			swmp_pkg::ST_LOAD: begin
				state_n = swmp_pkg::ST_RANK;
			end
			swmp_pkg::ST_RANK: begin
				if (cyc_q == LAST) begin
					state_n = swmp_pkg::ST_DONE;
				end
			end
			swmp_pkg::ST_DONE: begin
				if (out_free) begin
					state_n = swmp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = swmp_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready       = (state_q == swmp_pkg::ST_IDLE);
		ctl.shift      = accept && in_detected;
		ctl.load_probe = (state_q == swmp_pkg::ST_LOAD);
		ctl.rotate     = (state_q == swmp_pkg::ST_RANK);
		load_out       = (state_q == swmp_pkg::ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= swmp_pkg::ST_IDLE;
			count_q   <= '0;
			ws_q      <= swmp_pkg::CFG_W'(5);
			cyc_q     <= '0;
			has_pos_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_we) begin
				ws_q <= cfg_wdata;
			end
			if (accept) begin
				has_pos_q <= in_detected;
				if (in_detected) begin
					// a full window drops its oldest as the new sample goes in
					if (!full) begin
						count_q <= count_q + CW'(1);
					end
				end else if (count_q != '0) begin
					count_q <= count_q - CW'(1);
				end
			end
			if (state_q == swmp_pkg::ST_LOAD) begin
				cyc_q <= '0;
			end else if (state_q == swmp_pkg::ST_RANK) begin
				cyc_q <= cyc_q + IW'(1);
			end
		end
	end

	assign count   = count_q;
	assign target  = IW'(count_q >> 1);
	assign has_pos = has_pos_q;

	`SWMP_ASSERT_NEXT(a_count_grows, clk, arst_n, accept && in_detected && !full, count_q == $past(count_q) + CW'(1), "window count did not grow on append")
	`SWMP_ASSERT_NEXT(a_miss_direct, clk, arst_n, accept && !in_detected, (state_q == swmp_pkg::ST_DONE) && !has_pos_q, "missed detection did not go straight to result")
	`SWMP_ASSERT_NEXT(a_rank_len, clk, arst_n, (state_q == swmp_pkg::ST_RANK) && (cyc_q == LAST), state_q == swmp_pkg::ST_DONE, "rank pass overran the ring length")

endmodule
